FILE: hw/rtl/assert_macros.svh
// shared assertion macros for the warp address unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define PWA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property that must hold from the cycle after the antecedent
`define PWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/pwa_pkg.sv
package pwa_pkg;

  localparam int QBITS = 16;
  localparam int COEF_W = 40;
  localparam int PERSP_W = 32;
  localparam int FRAC_SHIFT = 10;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W = 3;
  localparam logic signed [PERSP_W-1:0] ONE_Q30 = 32'sh4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_A     = 3'd0,
    REG_COEF_B     = 3'd1,
    REG_COEF_C     = 3'd2,
    REG_COEF_D     = 3'd3,
    REG_COEF_E     = 3'd4,
    REG_COEF_F     = 3'd5,
    REG_PERSP_GH   = 3'd6,
    REG_FRAME_DIMS = 3'd7
  } pwa_reg_t;

  typedef struct packed {
    logic [15:0] src_x;
    logic [15:0] src_y;
    logic [31:0] pixel;
  } pwa_in_word_t;

  typedef struct packed {
    logic [15:0] dest_x;
    logic [15:0] dest_y;
    logic [31:0] dest_address;
    logic        in_bounds;
    logic [31:0] pixel_out;
  } pwa_out_word_t;

  typedef struct packed {
    logic valid;
    logic den_ok;
    logic neg_x;
    logic neg_y;
    logic big_x;
    logic big_y;
  } pwa_flags_t;

endpackage

FILE: hw/rtl/pwa_front.sv
module pwa_front #(
  parameter int COORD_BITS = 16,
  parameter int NUM_W = 58,
  parameter int DEN_W = 50,
  parameter int DIV_W = 68
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        adv,
  input  logic                        in_take,
  input  pwa_pkg::pwa_in_word_t       in_word,
  input  logic signed [39:0]          coef_a,
  input  logic signed [39:0]          coef_b,
  input  logic signed [39:0]          coef_c,
  input  logic signed [39:0]          coef_d,
  input  logic signed [39:0]          coef_e,
  input  logic signed [39:0]          coef_f,
  input  logic [63:0]                 persp_gh,
  output pwa_pkg::pwa_flags_t         flags_o,
  output logic [DIV_W-1:0]            rem_x_o,
  output logic [DIV_W-1:0]            rem_y_o,
  output logic [DEN_W-1:0]            den_o,
  output logic [31:0]                 pixel_o
);
  import pwa_pkg::*;

  localparam int PROD_W = COEF_W + COORD_BITS + 1;
  localparam int GP_W = PERSP_W + COORD_BITS + 1;

  logic signed [COORD_BITS:0] xs, ys;
  logic signed [PERSP_W-1:0]  g, h;
  logic signed [PROD_W-1:0]   pa_nxt, pb_nxt, pd_nxt, pe_nxt;
  logic signed [PROD_W-1:0]   pa_r, pb_r, pd_r, pe_r;
  logic signed [GP_W-1:0]     pg_nxt, ph_nxt, pg_r, ph_r;
  logic                       va_r;
  logic [31:0]                pix_a_r;

  logic signed [NUM_W-1:0]    numx, numy;
  logic signed [DEN_W-1:0]    den;
  logic [NUM_W-1:0]           magx, magy;
  pwa_flags_t                 flags_r;
  logic [DIV_W-1:0]           remx_r, remy_r;
  logic [DEN_W-1:0]           den_r;
  logic [31:0]                pix_b_r;

  assign xs = $signed({1'b0, in_word.src_x[COORD_BITS-1:0]});
  assign ys = $signed({1'b0, in_word.src_y[COORD_BITS-1:0]});
  assign g  = $signed(persp_gh[31:0]);
  assign h  = $signed(persp_gh[63:32]);

  // products of stage a
  assign pa_nxt = coef_a * xs;
  assign pb_nxt = coef_b * ys;
  assign pd_nxt = coef_d * xs;
  assign pe_nxt = coef_e * ys;
  assign pg_nxt = g * xs;
  assign ph_nxt = h * ys;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (adv) begin
      va_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa_r    <= pa_nxt;
      pb_r    <= pb_nxt;
      pd_r    <= pd_nxt;
      pe_r    <= pe_nxt;
      pg_r    <= pg_nxt;
      ph_r    <= ph_nxt;
      pix_a_r <= in_word.pixel;
    end
  end

  // sums of stage b
  assign numx = NUM_W'(pa_r) + NUM_W'(pb_r) + NUM_W'(coef_c);
  assign numy = NUM_W'(pd_r) + NUM_W'(pe_r) + NUM_W'(coef_f);
  assign den  = DEN_W'(pg_r) + DEN_W'(ph_r) + DEN_W'(ONE_Q30);
  assign magx = numx[NUM_W-1] ? NUM_W'(-numx) : NUM_W'(numx);
  assign magy = numy[NUM_W-1] ? NUM_W'(-numy) : NUM_W'(numy);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r.valid <= 1'b0;
    end else if (adv) begin
      flags_r.valid  <= va_r;
      flags_r.den_ok <= (den > 0);
      flags_r.neg_x  <= numx[NUM_W-1];
      flags_r.neg_y  <= numy[NUM_W-1];
      flags_r.big_x  <= 1'b0;
      flags_r.big_y  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      remx_r         <= {magx, {FRAC_SHIFT{1'b0}}};
      remy_r         <= {magy, {FRAC_SHIFT{1'b0}}};
      den_r          <= den;
      pix_b_r        <= pix_a_r;
    end
  end

  assign flags_o = flags_r;
  assign rem_x_o = remx_r;
  assign rem_y_o = remy_r;
  assign den_o   = den_r;
  assign pixel_o = pix_b_r;

endmodule

FILE: hw/rtl/pwa_div_cell.sv
module pwa_div_cell #(
  parameter int BIT = 0,
  parameter int DEN_W = 50,
  parameter int DIV_W = 68
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  pwa_pkg::pwa_flags_t    flags_i,
  input  logic [DIV_W-1:0]       rem_x_i,
  input  logic [DIV_W-1:0]       rem_y_i,
  input  logic [DEN_W-1:0]       den_i,
  input  logic [15:0]            q_x_i,
  input  logic [15:0]            q_y_i,
  input  logic [31:0]            pixel_i,
  output pwa_pkg::pwa_flags_t    flags_o,
  output logic [DIV_W-1:0]       rem_x_o,
  output logic [DIV_W-1:0]       rem_y_o,
  output logic [DEN_W-1:0]       den_o,
  output logic [15:0]            q_x_o,
  output logic [15:0]            q_y_o,
  output logic [31:0]            pixel_o
);
  import pwa_pkg::*;

  logic [DIV_W-1:0] dsh;
  logic             ge_x, ge_y;
  pwa_flags_t       flags_nxt, flags_r;
  logic [DIV_W-1:0] remx_nxt, remy_nxt, remx_r, remy_r;
  logic [15:0]      qx_nxt, qy_nxt, qx_r, qy_r;
  logic [DEN_W-1:0] den_r;
  logic [31:0]      pix_r;

  assign dsh  = DIV_W'(den_i) << BIT;
  assign ge_x = (rem_x_i >= dsh);
  assign ge_y = (rem_y_i >= dsh);

  generate
    if (BIT == QBITS) begin : g_range
      // quotient would not fit the coordinate width
      always_comb begin
        flags_nxt       = flags_i;
        flags_nxt.big_x = flags_i.big_x | ge_x;
        flags_nxt.big_y = flags_i.big_y | ge_y;
        remx_nxt        = rem_x_i;
        remy_nxt        = rem_y_i;
        qx_nxt          = q_x_i;
        qy_nxt          = q_y_i;
      end
    end else begin : g_bit
      always_comb begin
        flags_nxt = flags_i;
        remx_nxt  = ge_x ? (rem_x_i - dsh) : rem_x_i;
        remy_nxt  = ge_y ? (rem_y_i - dsh) : rem_y_i;
        qx_nxt    = q_x_i;
        qy_nxt    = q_y_i;
        qx_nxt[BIT] = ge_x;
        qy_nxt[BIT] = ge_y;
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r.valid <= 1'b0;
    end else if (adv) begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      remx_r         <= remx_nxt;
      remy_r         <= remy_nxt;
      qx_r           <= qx_nxt;
      qy_r           <= qy_nxt;
      den_r          <= den_i;
      pix_r          <= pixel_i;
    end
  end

  assign flags_o = flags_r;
  assign rem_x_o = remx_r;
  assign rem_y_o = remy_r;
  assign den_o   = den_r;
  assign q_x_o   = qx_r;
  assign q_y_o   = qy_r;
  assign pixel_o = pix_r;

endmodule

FILE: hw/rtl/pwa_back.sv
module pwa_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  pwa_pkg::pwa_flags_t    flags_i,
  input  logic [15:0]            q_x_i,
  input  logic [15:0]            q_y_i,
  input  logic [31:0]            pixel_i,
  input  logic [31:0]            frame_dims,
  output logic                   out_valid,
  output pwa_pkg::pwa_out_word_t out_word
);
  import pwa_pkg::*;

  logic [15:0]   width, height;
  logic          fail_x, fail_y, ok;
  pwa_out_word_t word_nxt, word_r;
  logic          valid_r;

  assign width  = frame_dims[15:0];
  assign height = frame_dims[31:16];

  // negative quotient survives only when it truncates to zero
  assign fail_x = flags_i.big_x | (flags_i.neg_x & (q_x_i != '0));
  assign fail_y = flags_i.big_y | (flags_i.neg_y & (q_y_i != '0));
  assign ok     = flags_i.den_ok & ~fail_x & ~fail_y & (q_x_i < width) & (q_y_i < height);

  always_comb begin
    word_nxt              = '0;
    word_nxt.pixel_out    = pixel_i;
    word_nxt.in_bounds    = ok;
    if (ok) begin
      word_nxt.dest_x       = q_x_i;
      word_nxt.dest_y       = q_y_i;
      word_nxt.dest_address = 32'(q_y_i) * 32'(width) + 32'(q_x_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= flags_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

FILE: hw/rtl/projective_warp_address_unit.sv
// channel   | ports                          | direction
// ----------+--------------------------------+----------
// input     | in_valid, in_ready, in_word    | in
// result    | out_valid, out_ready, out_word | out
// config    | cfg_we, cfg_index, cfg_data    | in
//
// one word per clock while the output slot is free or being emptied; results pass through
// 20 register stages: two arithmetic stages, 17 divider cells, one output stage
// all stages move together; a waiting result holds the whole chain
// reset is synchronous, active low; it loads the identity map and a 640x480 frame
module projective_warp_address_unit #(
  parameter int COORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  pwa_pkg::pwa_in_word_t  in_word,
  output logic                   out_valid,
  input  logic                   out_ready,
  output pwa_pkg::pwa_out_word_t out_word,
  input  logic                   cfg_we,
  input  logic [pwa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pwa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pwa_pkg::*;

  // numerator magnitude q.20, shifted left by ten for the q.30 denominator
  localparam int NUM_W = COEF_W + COORD_BITS + 2;
  localparam int DEN_W = PERSP_W + COORD_BITS + 2;
  localparam int DIV_W = NUM_W + FRAC_SHIFT;
  localparam int NCELL = QBITS + 1;

  // configuration registers
  logic signed [COEF_W-1:0] coef_a_r, coef_b_r, coef_c_r;
  logic signed [COEF_W-1:0] coef_d_r, coef_e_r, coef_f_r;
  logic [63:0]              persp_gh_r;
  logic [31:0]              frame_dims_r;

  logic adv;

  // divider chain taps, one entry per cell boundary
  pwa_flags_t       flg  [0:NCELL];
  logic [DIV_W-1:0] remx [0:NCELL];
  logic [DIV_W-1:0] remy [0:NCELL];
  logic [DEN_W-1:0] den  [0:NCELL];
  logic [15:0]      qx   [0:NCELL];
  logic [15:0]      qy   [0:NCELL];
  logic [31:0]      pix  [0:NCELL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_a_r     <= 40'sd1048576;
      coef_b_r     <= '0;
      coef_c_r     <= '0;
      coef_d_r     <= '0;
      coef_e_r     <= 40'sd1048576;
      coef_f_r     <= '0;
      persp_gh_r   <= '0;
      frame_dims_r <= 32'd31457920;
    end else if (cfg_we) begin
      unique case (pwa_reg_t'(cfg_index))
        REG_COEF_A:     coef_a_r     <= cfg_data[COEF_W-1:0];
        REG_COEF_B:     coef_b_r     <= cfg_data[COEF_W-1:0];
        REG_COEF_C:     coef_c_r     <= cfg_data[COEF_W-1:0];
        REG_COEF_D:     coef_d_r     <= cfg_data[COEF_W-1:0];
        REG_COEF_E:     coef_e_r     <= cfg_data[COEF_W-1:0];
        REG_COEF_F:     coef_f_r     <= cfg_data[COEF_W-1:0];
        REG_PERSP_GH:   persp_gh_r   <= cfg_data;
        REG_FRAME_DIMS: frame_dims_r <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // the chain moves whenever the output slot is free or being emptied
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  pwa_front #(
    .COORD_BITS(COORD_BITS), .NUM_W(NUM_W), .DEN_W(DEN_W), .DIV_W(DIV_W)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .in_take(in_valid), .in_word(in_word),
    .coef_a(coef_a_r), .coef_b(coef_b_r), .coef_c(coef_c_r),
    .coef_d(coef_d_r), .coef_e(coef_e_r), .coef_f(coef_f_r),
    .persp_gh(persp_gh_r),
    .flags_o(flg[0]), .rem_x_o(remx[0]), .rem_y_o(remy[0]),
    .den_o(den[0]), .pixel_o(pix[0])
  );

  assign qx[0] = '0;
  assign qy[0] = '0;

  // first cell catches quotients of 2^16 and up, the rest make one bit each
  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    pwa_div_cell #(
      .BIT(QBITS - i), .DEN_W(DEN_W), .DIV_W(DIV_W)
    ) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .flags_i(flg[i]), .rem_x_i(remx[i]), .rem_y_i(remy[i]), .den_i(den[i]),
      .q_x_i(qx[i]), .q_y_i(qy[i]), .pixel_i(pix[i]),
      .flags_o(flg[i+1]), .rem_x_o(remx[i+1]), .rem_y_o(remy[i+1]),
      .den_o(den[i+1]), .q_x_o(qx[i+1]), .q_y_o(qy[i+1]), .pixel_o(pix[i+1])
    );
  end

  pwa_back u_back (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .flags_i(flg[NCELL]), .q_x_i(qx[NCELL]), .q_y_i(qy[NCELL]),
    .pixel_i(pix[NCELL]), .frame_dims(frame_dims_r),
    .out_valid(out_valid), .out_word(out_word)
  );

`include "assert_macros.svh"

  `PWA_ASSERT(a_oob_zero, out_valid && !out_word.in_bounds |-> out_word.dest_address == '0 && out_word.dest_x == '0 && out_word.dest_y == '0, "out of bounds word carries a location")
  `PWA_ASSERT(a_in_frame, out_valid && out_word.in_bounds |-> out_word.dest_x < frame_dims_r[15:0] && out_word.dest_y < frame_dims_r[31:16], "in bounds word outside frame")
  `PWA_ASSERT_NEXT(a_hold_chain, !adv, $stable(flg[0].valid) && $stable(flg[NCELL].valid) && $stable(out_word), "chain moved during stall")

endmodule
